// ----- sv/vid_pkg.sv -----
// Package for the vertex index dedup block: field widths, parameter defaults,
// configuration register codes and the control struct passed along the match chain.
// No dependencies.
package vid_pkg;

  // Parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned INDEX_BITS_DEF  = 16;

  // Fixed port field widths
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned DRAW_W     = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_UVS     = 1'b0,
    CFG_USE_NORMALS = 1'b1
  } cfg_reg_e;

  // Control bits of one corner moving down the chain
  typedef struct packed {
    logic valid;   // slot holds a corner
    logic start;   // corner opens a new mesh and clears the table as it passes
    logic done;    // key matched or was appended upstream
    logic is_new;  // key was appended upstream
  } vid_ctl_t;

endpackage

// ----- sv/vid_ifs.sv -----
// Valid/ready channel interfaces for face corners in and draw indices out.
// Depends on vid_pkg for the field widths.
interface vid_in_if
  import vid_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               start_mesh;
  logic [FIELD_W-1:0] vertex_index;
  logic [FIELD_W-1:0] uv_index;
  logic [FIELD_W-1:0] normal_index;

  modport source (output valid, start_mesh, vertex_index, uv_index, normal_index,
                  input ready);
  modport sink   (input valid, start_mesh, vertex_index, uv_index, normal_index,
                  output ready);
endinterface

interface vid_out_if
  import vid_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DRAW_W-1:0]  draw_index;
  logic               is_new;
  logic [FIELD_W-1:0] src_vertex;
  logic [FIELD_W-1:0] src_uv;
  logic [FIELD_W-1:0] src_normal;
  logic               overflow;

  modport source (output valid, draw_index, is_new, src_vertex, src_uv, src_normal,
                  overflow, input ready);
  modport sink   (input valid, draw_index, is_new, src_vertex, src_uv, src_normal,
                  overflow, output ready);
endinterface

// ----- sv/vid_cell.sv -----
// One match cell: holds one table entry and its occupancy flag, plus the slot
// for the corner currently passing. Depends on vid_pkg.
module vid_cell
  import vid_pkg::*;
#(
  parameter int unsigned POS_W    = 10,
  parameter int unsigned KEY_W    = 48,
  parameter int unsigned CELL_POS = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  vid_ctl_t         ctl_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic [KEY_W-1:0] key_i,
  output vid_ctl_t         ctl_o,
  output logic [POS_W-1:0] pos_o,
  output logic [KEY_W-1:0] key_o,
  output logic             occ_o
);

  vid_ctl_t         ctl_q;
  logic [POS_W-1:0] pos_q;
  logic [KEY_W-1:0] key_q;
  logic             occ_q, occ_d;
  logic [KEY_W-1:0] ent_q;
  logic             eff_occ, live, hit, claim;

  // Entry as seen by the passing corner; a start corner sees it as empty
  assign eff_occ = occ_q & ~(ctl_q.valid & ctl_q.start);
  assign live    = ctl_q.valid & ~ctl_q.done;
  assign hit     = live & eff_occ & (ent_q == key_q);
  assign claim   = live & ~eff_occ;
  assign occ_d   = eff_occ | claim;

  // Hand the corner on with this cell's verdict merged in
  always_comb begin
    ctl_o        = ctl_q;
    ctl_o.done   = ctl_q.done | hit | claim;
    ctl_o.is_new = ctl_q.is_new | claim;
    pos_o        = (hit || claim) ? POS_W'(CELL_POS) : pos_q;
    key_o        = key_q;
  end

  assign occ_o = occ_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      occ_q <= 1'b0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
      occ_q <= occ_d;
    end
  end

  // Payload and stored key
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pos_q <= pos_i;
      key_q <= key_i;
      if (claim) begin
        ent_q <= key_q;
      end
    end
  end

endmodule

// ----- sv/vid_chain.sv -----
// Row of match cells, one per table entry; corners step one cell per advance.
// Depends on vid_pkg and vid_cell.
module vid_chain
  import vid_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_W = 3 * INDEX_BITS_DEF,
  localparam int unsigned POS_W = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  vid_ctl_t         ctl_i,
  input  logic [KEY_W-1:0] key_i,
  output vid_ctl_t         ctl_o,
  output logic [POS_W-1:0] pos_o,
  output logic [KEY_W-1:0] key_o
);

  vid_ctl_t         ctl_w [DEPTH+1];
  logic [POS_W-1:0] pos_w [DEPTH+1];
  logic [KEY_W-1:0] key_w [DEPTH+1];
  logic [DEPTH-1:0] occ;

  // Head of the chain
  assign ctl_w[0] = ctl_i;
  assign pos_w[0] = '0;
  assign key_w[0] = key_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    vid_cell #(
      .POS_W   (POS_W),
      .KEY_W   (KEY_W),
      .CELL_POS(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv_i),
      .ctl_i (ctl_w[k]),
      .pos_i (pos_w[k]),
      .key_i (key_w[k]),
      .ctl_o (ctl_w[k+1]),
      .pos_o (pos_w[k+1]),
      .key_o (key_w[k+1]),
      .occ_o (occ[k])
    );
  end

  // Tail of the chain
  assign ctl_o = ctl_w[DEPTH];
  assign pos_o = pos_w[DEPTH];
  assign key_o = key_w[DEPTH];

  // A corner marked new has always been resolved
  a_new_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.valid && ctl_o.is_new) |-> ctl_o.done)
    else $error("new corner left the chain unresolved");

  // A start corner always takes entry zero, so it leaves the chain resolved
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.valid && ctl_o.start) |-> ctl_o.done)
    else $error("start corner left the chain unresolved");

  // Table contents move only with the chain
  a_occ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(occ))
    else $error("occupancy changed during a stall");

endmodule

// ----- sv/vertex_index_dedup.sv -----
// Top level of the vertex index dedup block: mode registers, key forming,
// match chain and output register. Depends on vid_pkg, vid_ifs and vid_chain.
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   start_mesh, vertex_index, uv_index, normal_index
//  out_o    out  valid/ready   draw_index, is_new, src_vertex, src_uv, src_normal,
//                              overflow
//  cfg      in   cfg_we_i      cfg_idx_i selects use_uvs / use_normals, cfg_data_i
//
// One corner is accepted per cycle while the output is not stalled; each result passes
// through the match chain cells and then the output register before it leaves.
// Reset clears the mode registers and all occupancy flags at once; no clearing pass.
// A start corner empties the table as it walks the chain.
// A stalled output freezes the whole chain; ready is high whenever the output
// register is empty or being taken.
module vertex_index_dedup
  import vid_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vid_in_if.sink                in_i,
  vid_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned KEY_W = 3 * INDEX_BITS;
  localparam int unsigned POS_W = $clog2(TABLE_DEPTH);

  logic                  use_uvs_q, use_normals_q;
  logic                  adv;
  logic [INDEX_BITS-1:0] v_idx, t_idx, n_idx;
  logic [KEY_W-1:0]      head_key, tail_key;
  vid_ctl_t              head_ctl, tail_ctl;
  logic [POS_W-1:0]      tail_pos;

  logic                  out_valid_q;
  logic [DRAW_W-1:0]     draw_q;
  logic                  is_new_q, overflow_q;
  logic [FIELD_W-1:0]    src_v_q, src_t_q, src_n_q;

  // Mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_uvs_q     <= 1'b0;
      use_normals_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USE_UVS:     use_uvs_q     <= cfg_data_i[0];
        CFG_USE_NORMALS: use_normals_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Chain moves whenever the output register can take its tail
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Masked key; parts left out of the key are zero
  assign v_idx    = INDEX_BITS'(in_i.vertex_index);
  assign t_idx    = use_uvs_q     ? INDEX_BITS'(in_i.uv_index)     : '0;
  assign n_idx    = use_normals_q ? INDEX_BITS'(in_i.normal_index) : '0;
  assign head_key = {n_idx, t_idx, v_idx};

  always_comb begin
    head_ctl        = '0;
    head_ctl.valid  = in_i.valid;
    head_ctl.start  = in_i.start_mesh;
  end

  vid_chain #(
    .DEPTH(TABLE_DEPTH),
    .KEY_W(KEY_W)
  ) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .ctl_i (head_ctl),
    .key_i (head_key),
    .ctl_o (tail_ctl),
    .pos_o (tail_pos),
    .key_o (tail_key)
  );

  // Output register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail_ctl.valid;
    end
  end

  // Output register: payload; an unresolved corner found the table full
  always_ff @(posedge clk_i) begin
    if (adv) begin
      draw_q     <= tail_ctl.done ? DRAW_W'(tail_pos) : '0;
      is_new_q   <= tail_ctl.is_new;
      overflow_q <= ~tail_ctl.done;
      src_v_q    <= FIELD_W'(tail_key[INDEX_BITS-1:0]);
      src_t_q    <= FIELD_W'(tail_key[2*INDEX_BITS-1:INDEX_BITS]);
      src_n_q    <= FIELD_W'(tail_key[3*INDEX_BITS-1:2*INDEX_BITS]);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.draw_index = draw_q;
  assign out_o.is_new     = is_new_q;
  assign out_o.overflow   = overflow_q;
  assign out_o.src_vertex = src_v_q;
  assign out_o.src_uv     = src_t_q;
  assign out_o.src_normal = src_n_q;

  // An appended key never reports overflow
  a_new_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(is_new_q && overflow_q))
    else $error("result both new and overflowed");

  // Overflow reports draw index zero
  a_ovf_draw0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && overflow_q) |-> (draw_q == '0))
    else $error("overflow with nonzero draw index");

  // A result waiting at the output is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("pending result lost during stall");

endmodule
